>>> hw/rtl/hog_pkg.sv
// Shared types and constants for the cell orientation histogram.
package hog_pkg;
  localparam int NumBins     = 9;
  localparam int MagFracBits = 4;
  localparam int AccW        = 20;
  localparam int SqW         = 18 + 2 * MagFracBits;
  localparam int MagW        = (SqW + 1) / 2;
  localparam int SqrtSteps   = MagW;
  localparam int QuoSteps    = 37;
  localparam int StepCntW    = 6;
  localparam logic [AccW-1:0] AccMax = '1;

  typedef enum logic [2:0] {
    StIdle, StSqrt, StAcc, StDivLoad, StDiv, StOut
  } hog_state_e;

  typedef struct packed {
    logic load;
    logic sqrt_step;
    logic acc;
    logic div_start;
    logic div_step;
    logic next_bin;
    logic clear;
  } hog_cmd_t;

  typedef struct packed {
    logic step_done;
    logic cell_end;
    logic last_bin;
  } hog_sts_t;
endpackage

>>> hw/rtl/hog_cell_orientation_histogram.sv
// Top level of the cell orientation histogram.
// Each pixel item is handled as a load, 13 square-root steps (one root bit per cycle
// from the iterative square-root unit) and an accumulate step. On a cell end the
// nine bins follow, each as one operand load, 37 steps of the bit-serial restoring
// divider and an output state that holds while the receiver stalls; the next item
// is taken once bin 8 has been delivered.
module hog_cell_orientation_histogram (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic signed [8:0] grad_x_i,
  input  logic signed [8:0] grad_y_i,
  input  logic              cell_end_i,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [3:0]        bin_index_o,
  output logic [15:0]       bin_value_o,
  output logic              last_bin_o
);
  import hog_pkg::*;

  hog_cmd_t cmd;
  hog_sts_t sts;

  hog_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid, .in_ready, .out_valid, .out_ready,
    .sts_i(sts), .cmd_o(cmd)
  );

  hog_datapath u_dp (
    .clk_i, .rst_ni, .grad_x_i, .grad_y_i, .cell_end_i,
    .cmd_i(cmd), .sts_o(sts), .bin_index_o, .bin_value_o
  );

  assign last_bin_o = sts.last_bin;
endmodule

>>> hw/rtl/hog_datapath.sv
// Datapath: angle binning, iterative square root, accumulators and divider.
module hog_datapath (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic signed [8:0]   grad_x_i,
  input  logic signed [8:0]   grad_y_i,
  input  logic                cell_end_i,
  input  hog_pkg::hog_cmd_t   cmd_i,
  output hog_pkg::hog_sts_t   sts_o,
  output logic [3:0]          bin_index_o,
  output logic [15:0]         bin_value_o
);
  import hog_pkg::*;

  logic [SqW-1:0]      src_q, src_d;
  logic [MagW+1:0]     pr_q, pr_d;
  logic [MagW-1:0]     root_q, root_d;
  logic [StepCntW-1:0] cnt_q, cnt_d;
  logic [3:0]          bin_q, bin_d;
  logic                nz_q, nz_d, end_q, end_d;
  logic [AccW-1:0]     acc_q [NumBins];
  logic [AccW-1:0]     cell_q;
  logic [3:0]          oidx_q, oidx_d;
  logic [AccW:0]       drem_q, drem_d;
  logic [36:0]         quo_q, quo_d;
  logic [36:0]         num_q, num_d;

  logic [8:0]      ax, ay;
  logic [9:0]      s;
  logic [16:0]     t90;
  logic [8:0]      ang;
  logic [3:0]      abin;
  logic [17:0]     sq;
  logic [MagW+1:0] trial;
  logic [MagW+1:0] cur;
  logic [AccW:0]   dtrial;
  logic [AccW:0]   bsum, csum;

  // Angle bins follow from comparing 90*a/s with 20k; floor(90a/s)>=m iff 90a>=m*s.
  always_comb begin
    ax  = grad_x_i[8] ? 9'(-grad_x_i) : 9'(grad_x_i);
    ay  = grad_y_i[8] ? 9'(-grad_y_i) : 9'(grad_y_i);
    s   = 10'(ax) + 10'(ay);
    t90 = 17'(grad_x_i[8] ? ax : ay) * 17'd90;
    ang = 9'd0;
    for (int m = 1; m < 90; m++) begin
      if (t90 >= 17'(m) * 17'(s)) ang = 9'(m);
    end
    if (grad_x_i[8]) ang = ang + 9'd90;
    if (grad_y_i[8] && ang != 9'd0) ang = 9'd180 - ang;
    abin = 4'd0;
    for (int k = 1; k < NumBins; k++) begin
      if (ang >= 9'(20 * k)) abin = 4'(k);
    end
    if (abin > 4'(NumBins - 1)) abin = 4'(NumBins - 1);
  end

  assign sq = 18'(ax) * 18'(ax) + 18'(ay) * 18'(ay);

  // Restoring square root, one root bit per step; operand bits enter two at a time.
  always_comb begin
    trial  = {root_q, 2'b01};
    cur    = {pr_q[MagW-1:0], src_q[SqW-1:SqW-2]};
    src_d  = src_q;
    pr_d   = pr_q;
    root_d = root_q;
    bin_d  = bin_q;
    nz_d   = nz_q;
    end_d  = end_q;
    if (cmd_i.load) begin
      src_d  = SqW'(sq) << (2 * MagFracBits);
      pr_d   = '0;
      root_d = '0;
      nz_d   = (ax != 9'd0) || (ay != 9'd0);
      end_d  = cell_end_i;
      priority if (ax == 9'd0)      bin_d = 4'd4;
      else if (ay == 9'd0)          bin_d = 4'd0;
      else                          bin_d = abin;
    end else if (cmd_i.sqrt_step) begin
      src_d = {src_q[SqW-3:0], 2'b00};
      if (cur >= trial) begin
        pr_d   = cur - trial;
        root_d = {root_q[MagW-2:0], 1'b1};
      end else begin
        pr_d   = cur;
        root_d = {root_q[MagW-2:0], 1'b0};
      end
    end
  end

  always_comb begin
    priority if (cmd_i.load || cmd_i.div_start)     cnt_d = '0;
    else if (cmd_i.sqrt_step || cmd_i.div_step)     cnt_d = cnt_q + 1'b1;
    else                                            cnt_d = cnt_q;
  end

  assign bsum = {1'b0, acc_q[bin_q]} + (AccW+1)'(root_q);
  assign csum = {1'b0, cell_q} + (AccW+1)'(root_q);

  // Restoring divider: (bin << 16) / cell, 37 quotient bits.
  always_comb begin
    dtrial = {drem_q[AccW-1:0], num_q[36]};
    drem_d = drem_q;
    quo_d  = quo_q;
    num_d  = num_q;
    oidx_d = oidx_q;
    if (cmd_i.div_start) begin
      drem_d = '0;
      quo_d  = '0;
      num_d  = {1'b0, acc_q[oidx_q], 16'h0};
    end else if (cmd_i.div_step) begin
      num_d = {num_q[35:0], 1'b0};
      if (dtrial >= {1'b0, cell_q}) begin
        drem_d = dtrial - {1'b0, cell_q};
        quo_d  = {quo_q[35:0], 1'b1};
      end else begin
        drem_d = dtrial;
        quo_d  = {quo_q[35:0], 1'b0};
      end
    end
    if (cmd_i.next_bin) oidx_d = oidx_q + 1'b1;
    if (cmd_i.clear)    oidx_d = '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_q  <= '0;
      pr_q   <= '0;
      root_q <= '0;
      cnt_q  <= '0;
      bin_q  <= '0;
      nz_q   <= 1'b0;
      end_q  <= 1'b0;
      oidx_q <= '0;
      drem_q <= '0;
      quo_q  <= '0;
      num_q  <= '0;
      cell_q <= '0;
      for (int i = 0; i < NumBins; i++) acc_q[i] <= '0;
    end else begin
      src_q  <= src_d;
      pr_q   <= pr_d;
      root_q <= root_d;
      cnt_q  <= cnt_d;
      bin_q  <= bin_d;
      nz_q   <= nz_d;
      end_q  <= end_d;
      oidx_q <= oidx_d;
      drem_q <= drem_d;
      quo_q  <= quo_d;
      num_q  <= num_d;
      if (cmd_i.clear) begin
        cell_q <= '0;
        for (int i = 0; i < NumBins; i++) acc_q[i] <= '0;
      end else if (cmd_i.acc && nz_q) begin
        acc_q[bin_q] <= bsum[AccW] ? AccMax : bsum[AccW-1:0];
        cell_q       <= csum[AccW] ? AccMax : csum[AccW-1:0];
      end
    end
  end

  assign sts_o.step_done = cmd_i.sqrt_step ? (cnt_q == StepCntW'(SqrtSteps - 1))
                                           : (cnt_q == StepCntW'(QuoSteps - 1));
  assign sts_o.cell_end  = end_q;
  assign sts_o.last_bin  = (oidx_q == 4'(NumBins - 1));
  assign bin_index_o     = oidx_q;
  assign bin_value_o     = (cell_q == '0) ? 16'h0 :
                           (quo_q[36:16] != '0) ? 16'hFFFF : quo_q[15:0];
endmodule

>>> hw/rtl/hog_ctrl.sv
// Controller state machine for the cell orientation histogram.
module hog_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  hog_pkg::hog_sts_t sts_i,
  output hog_pkg::hog_cmd_t cmd_o
);
  import hog_pkg::*;

  hog_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= StIdle;
    else         state_q <= state_d;
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle:    if (in_valid) state_d = StSqrt;
      StSqrt:    if (sts_i.step_done) state_d = StAcc;
      StAcc:     state_d = sts_i.cell_end ? StDivLoad : StIdle;
      StDivLoad: state_d = StDiv;
      StDiv:     if (sts_i.step_done) state_d = StOut;
      StOut:     if (out_ready) state_d = sts_i.last_bin ? StIdle : StDivLoad;
      default:   state_d = StIdle;
    endcase
  end

  always_comb begin
    cmd_o     = '0;
    in_ready  = 1'b0;
    out_valid = 1'b0;
    unique case (state_q)
      StIdle: begin
        in_ready   = 1'b1;
        cmd_o.load = in_valid;
      end
      StSqrt:    cmd_o.sqrt_step = 1'b1;
      StAcc:     cmd_o.acc = 1'b1;
      StDivLoad: cmd_o.div_start = 1'b1;
      StDiv:     cmd_o.div_step = 1'b1;
      StOut: begin
        out_valid = 1'b1;
        if (out_ready) begin
          cmd_o.next_bin = !sts_i.last_bin;
          cmd_o.clear    = sts_i.last_bin;
        end
      end
      default: ;
    endcase
  end
endmodule

>>> verif/hog_histogram_checker.sv
// Checker for the cell orientation histogram: predicts bins per cell and compares outputs.
`timescale 1ns / 100ps
module hog_histogram_checker (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid,
  input  logic              in_ready,
  input  logic signed [8:0] grad_x_i,
  input  logic signed [8:0] grad_y_i,
  input  logic              cell_end_i,
  input  logic              out_valid,
  input  logic              out_ready,
  input  logic [3:0]        bin_index_o,
  input  logic [15:0]       bin_value_o,
  input  logic              last_bin_o,
  output int                fail_count,
  output int                pending_bins
);
  import hog_pkg::*;

  localparam int DueDepth = 16;

  typedef struct packed {
    logic [3:0]  index;
    logic [15:0] value;
    logic        last;
  } bin_result_t;

  logic [AccW-1:0] bin_acc [NumBins];
  logic [AccW-1:0] cell_acc;
  bin_result_t     due_mem [DueDepth];
  int              due_wr;
  int              due_rd;

  function automatic logic [31:0] root_floor(logic [31:0] v);
    logic [31:0] r;
    r = 0;
    for (int b = 15; b >= 0; b--) begin
      if ((r | (32'd1 << b)) * (r | (32'd1 << b)) <= v) r = r | (32'd1 << b);
    end
    return r;
  endfunction

  function automatic int orient_bin(int x, int y);
    int ax, ay, a;
    ax = x < 0 ? -x : x;
    ay = y < 0 ? -y : y;
    if (x == 0) return 4;
    if (y == 0) return 0;
    if (x >= 0) a = (90 * ay) / (ax + ay);
    else a = 90 + (90 * ax) / (ax + ay);
    if (y < 0) a = -a;
    if (a < 0) a += 180;
    a = a / 20;
    if (a > NumBins - 1) a = NumBins - 1;
    return a;
  endfunction

  function automatic logic [AccW-1:0] acc_add(logic [AccW-1:0] a, logic [31:0] b);
    logic [32:0] s;
    s = a + b;
    return (s > AccMax) ? AccMax : s[AccW-1:0];
  endfunction

  task automatic add_pixel(int x, int y, logic last);
    logic [31:0] mag;
    logic [63:0] q;
    int bn;
    bin_result_t r;
    if (x != 0 || y != 0) begin
      mag = root_floor(32'((x * x + y * y) << (2 * MagFracBits)));
      bn = orient_bin(x, y);
      bin_acc[bn] = acc_add(bin_acc[bn], mag);
      cell_acc = acc_add(cell_acc, mag);
    end
    if (last) begin
      for (int i = 0; i < NumBins; i++) begin
        q = 0;
        if (cell_acc != 0) begin
          q = (64'(bin_acc[i]) << 16) / cell_acc;
          if (q > 64'hFFFF) q = 64'hFFFF;
        end
        r.index = 4'(i);
        r.value = q[15:0];
        r.last = (i == NumBins - 1);
        if (due_wr - due_rd >= DueDepth) begin
          $display("%0t: expected-bin store overflow", $time);
          fail_count++;
        end
        due_mem[due_wr % DueDepth] = r;
        due_wr++;
        bin_acc[i] = 0;
      end
      cell_acc = 0;
    end
  endtask

  always @(posedge clk_i) begin
    bin_result_t e;
    if (!rst_ni) begin
      fail_count = 0;
      pending_bins = 0;
      due_wr = 0;
      due_rd = 0;
      cell_acc = 0;
      for (int i = 0; i < NumBins; i++) bin_acc[i] = 0;
    end else begin
      if (in_valid && in_ready) add_pixel(int'(grad_x_i), int'(grad_y_i), cell_end_i);
      if (out_valid && out_ready) begin
        if (due_wr == due_rd) begin
          $display("%0t: unexpected bin: index %0d value %0d", $time, bin_index_o, bin_value_o);
          fail_count++;
        end else begin
          e = due_mem[due_rd % DueDepth];
          due_rd++;
          if (e.index !== bin_index_o || e.value !== bin_value_o || e.last !== last_bin_o) begin
            $display("%0t: bin mismatch: expected idx %0d val %0d last %0b, got %0d %0d %0b",
                     $time, e.index, e.value, e.last, bin_index_o, bin_value_o, last_bin_o);
            fail_count++;
          end
        end
      end
      pending_bins = due_wr - due_rd;
    end
  end
endmodule

>>> verif/tb.sv
// Testbench top for the cell orientation histogram: stimulus, idling and verdict.
`timescale 1ns / 100ps
module tb;
  logic              clk_i = 0;
  logic              rst_ni = 0;
  logic              in_valid = 0;
  logic              in_ready;
  logic signed [8:0] grad_x_i = 0;
  logic signed [8:0] grad_y_i = 0;
  logic              cell_end_i = 0;
  logic              out_valid;
  logic              out_ready = 0;
  logic [3:0]        bin_index_o;
  logic [15:0]       bin_value_o;
  logic              last_bin_o;
  int                fail_count;
  int                pending_bins;
  int                idle_cycles = 0;
  int                pixel_count = 0;
  int                cell_count = 0;
  bit                calm = 0;

  always #2 clk_i = ~clk_i;

  hog_cell_orientation_histogram dut (.*);
  hog_histogram_checker checker_u (.*);

  always @(posedge clk_i) begin
    if (in_valid && in_ready) pixel_count <= pixel_count + 1;
    if (out_valid && out_ready && last_bin_o) cell_count <= cell_count + 1;
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 20000) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // receiver stalls in bursts until calm is set
  always @(posedge clk_i) begin
    int n;
    if (!calm && $urandom_range(0, 3) == 0) begin
      n = $urandom_range(1, 17);
      out_ready <= 0;
      repeat (n) @(posedge clk_i);
    end
    out_ready <= 1;
  end

  task automatic send_pixel(int x, int y, bit last);
    if (!calm && $urandom_range(0, 4) == 0) begin
      in_valid <= 0;
      repeat ($urandom_range(1, 17)) @(posedge clk_i);
    end
    in_valid <= 1;
    grad_x_i <= 9'(x);
    grad_y_i <= 9'(y);
    cell_end_i <= last;
    @(posedge clk_i);
    while (!in_ready) @(posedge clk_i);
  endtask

  task automatic send_cell(int len);
    int x, y;
    for (int i = 0; i < len; i++) begin
      case ($urandom_range(0, 7))
        0: begin x = 0; y = $urandom_range(0, 510) - 255; end
        1: begin x = $urandom_range(0, 510) - 255; y = 0; end
        2: begin x = $urandom_range(0, 1) ? 255 : -255; y = $urandom_range(0, 1) ? 255 : -255; end
        default: begin x = $urandom_range(0, 510) - 255; y = $urandom_range(0, 510) - 255; end
      endcase
      send_pixel(x, y, i == len - 1);
    end
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);
    // directed: extremes, axes, zero gradient, empty cell, single-pixel cell
    send_pixel(255, 0, 0);
    send_pixel(-255, 0, 0);
    send_pixel(0, 255, 0);
    send_pixel(0, -255, 0);
    send_pixel(0, 0, 0);
    send_pixel(-256, -256, 0);
    send_pixel(255, 255, 0);
    send_pixel(-255, 255, 0);
    send_pixel(255, -255, 0);
    send_pixel(-1, -1, 0);
    send_pixel(1, 1, 0);
    send_pixel(-256, 255, 1);
    send_pixel(0, 0, 0);
    send_pixel(0, 0, 1);
    send_pixel(-170, 85, 1);
    send_pixel(0, 7, 0);
    send_pixel(-256, 0, 1);
    in_valid <= 0;
    @(posedge clk_i);
    while (pending_bins != 0) @(posedge clk_i);
    // random cells, mostly short
    while (pixel_count < 56) begin
      send_cell($urandom_range(1, 12));
    end
    calm = 1;
    send_cell(64);
    in_valid <= 0;
    @(posedge clk_i);
    while (pending_bins != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    $display("Covered %0d pixels in %0d cells, with axis, zero and extreme gradients.",
             pixel_count, cell_count);
    if (fail_count == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end
endmodule
